// ----- src/zsep_pkg.sv -----
// Shared types, constants and helpers of the ZIP stored-entry parser.
package zsep_pkg;

    localparam int ENTRY_INDEX_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] HDR_SIGNATURE = 32'h04034b50;
    localparam logic [4:0]  HDR_LAST      = 5'd29;
    localparam logic [4:0]  AT_METHOD     = 5'd8;
    localparam logic [4:0]  AT_SIZE       = 5'd18;
    localparam logic [4:0]  AT_NAMELEN    = 5'd26;
    localparam logic [4:0]  AT_EXTRALEN   = 5'd28;

    typedef enum logic [2:0] {
        K_NAME    = 3'd0,
        K_DATA    = 3'd1,
        K_EMPTY   = 3'd2,
        K_DROP    = 3'd3,
        K_VERDICT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        V_OK         = 2'd0,
        V_NO_ENTRIES = 2'd1,
        V_COMPRESSED = 2'd2
    } t_verdict;

    // One result; post selects the entry count after this word's entry bump.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
        t_verdict   verdict;
        logic       post;
    } t_res;

    // All results caused by one input word, slot 0 first.
    typedef struct packed {
        logic [1:0]     n;
        t_res [2:0]     slot;
    } t_bundle;

    function automatic t_res mk_res(t_kind kind, logic [7:0] value, logic last,
                                    t_verdict verdict, logic post);
        t_res r;
        r.kind    = kind;
        r.value   = value;
        r.last    = last;
        r.verdict = verdict;
        r.post    = post;
        return r;
    endfunction

endpackage

// ----- src/zsep_front.sv -----
// Header walker: consumes one archive word per cycle while i_accept is high and builds its result bundle.
module zsep_front
    import zsep_pkg::*;
#(
    parameter int ENTRY_INDEX_BITS = ENTRY_INDEX_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_byte_in,
    input  logic                        i_has_byte,
    input  logic                        i_end_of_file,
    output logic                        o_push,
    output t_bundle                     o_bundle,
    output logic [ENTRY_INDEX_BITS-1:0] o_entry_pre,
    output logic [ENTRY_INDEX_BITS-1:0] o_entry_post
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_EXTRA,
        PH_DATA,
        PH_DONE
    } t_phase;

    localparam logic [ENTRY_INDEX_BITS-1:0] KEPT_MAX = '1;

    t_phase                      r_phase, n_phase;
    logic [4:0]                  r_hcount, n_hcount;
    logic [31:0]                 r_sig, n_sig;
    logic                        r_meth, n_meth;
    logic [31:0]                 r_size, n_size;
    logic [15:0]                 r_name, n_name;
    logic [15:0]                 r_extra, n_extra;
    logic [31:0]                 r_data, n_data;
    logic [ENTRY_INDEX_BITS-1:0] r_kept, n_kept;
    logic                        r_stopped, n_stopped;

    t_bundle    bun;
    logic [1:0] cnt;
    logic       do_settle;
    logic [1:0] sz_sel;

    always_comb begin
        n_phase   = r_phase;
        n_hcount  = r_hcount;
        n_sig     = r_sig;
        n_meth    = r_meth;
        n_size    = r_size;
        n_name    = r_name;
        n_extra   = r_extra;
        n_data    = r_data;
        n_kept    = r_kept;
        n_stopped = r_stopped;
        bun       = '0;
        cnt       = 2'd0;
        do_settle = 1'b0;
        sz_sel    = 2'(r_hcount - AT_SIZE);

        if (r_phase != PH_DONE) begin
            if (i_has_byte && !r_stopped) begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_hcount == 5'd0) begin
                            n_meth  = 1'b0;
                            n_size  = '0;
                            n_name  = '0;
                            n_extra = '0;
                        end
                        if (r_hcount < 5'd4) begin
                            n_sig = {i_byte_in, r_sig[31:8]};
                        end else if (r_hcount == AT_METHOD || r_hcount == AT_METHOD + 5'd1) begin
                            if (i_byte_in != 8'd0) n_meth = 1'b1;
                        end else if (r_hcount >= AT_SIZE && r_hcount < AT_SIZE + 5'd4) begin
                            n_size[8*sz_sel +: 8] = i_byte_in;
                        end else if (r_hcount == AT_NAMELEN) begin
                            n_name[7:0] = i_byte_in;
                        end else if (r_hcount == AT_NAMELEN + 5'd1) begin
                            n_name[15:8] = i_byte_in;
                        end else if (r_hcount == AT_EXTRALEN) begin
                            n_extra[7:0] = i_byte_in;
                        end else if (r_hcount == AT_EXTRALEN + 5'd1) begin
                            n_extra[15:8] = i_byte_in;
                        end
                        // A bad signature halts parsing; the verdict still comes at end of file.
                        if (r_hcount == 5'd3 && n_sig != HDR_SIGNATURE) begin
                            n_stopped = 1'b1;
                            n_hcount  = 5'd0;
                        end else if (r_hcount == HDR_LAST) begin
                            n_hcount  = 5'd0;
                            n_data    = n_size;
                            do_settle = 1'b1;
                        end else begin
                            n_hcount = r_hcount + 5'd1;
                        end
                    end
                    PH_NAME: begin
                        if (!r_meth) begin
                            bun.slot[cnt] = mk_res(K_NAME, i_byte_in, 1'b0, V_OK, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                        n_name = r_name - 16'd1;
                        do_settle = (n_name == 16'd0);
                    end
                    PH_EXTRA: begin
                        n_extra = r_extra - 16'd1;
                        do_settle = (n_extra == 16'd0);
                    end
                    PH_DATA: begin
                        n_data = r_data - 32'd1;
                        if (!r_meth) begin
                            bun.slot[cnt] = mk_res(K_DATA, i_byte_in, n_data == 32'd0,
                                                   V_OK, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                        do_settle = (n_data == 32'd0);
                    end
                    default: begin
                    end
                endcase
            end

            if (do_settle) begin
                if (n_name != 16'd0) begin
                    n_phase = PH_NAME;
                end else if (n_extra != 16'd0) begin
                    n_phase = PH_EXTRA;
                end else if (n_data != 32'd0) begin
                    n_phase = PH_DATA;
                end else if (n_meth) begin
                    // A compressed entry that fits in the file ends the parse.
                    bun.slot[cnt] = mk_res(K_VERDICT, 8'd0, 1'b0, V_COMPRESSED, 1'b0);
                    cnt = cnt + 2'd1;
                    n_phase = PH_DONE;
                end else begin
                    if (n_size == 32'd0) begin
                        bun.slot[cnt] = mk_res(K_EMPTY, 8'd0, 1'b1, V_OK, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                    if (r_kept != KEPT_MAX) n_kept = r_kept + 1'b1;
                    n_phase  = PH_HEADER;
                    n_hcount = 5'd0;
                end
            end

            if (i_end_of_file && n_phase != PH_DONE) begin
                if (!n_stopped && !n_meth &&
                    (n_phase == PH_NAME || n_phase == PH_EXTRA || n_phase == PH_DATA)) begin
                    bun.slot[cnt] = mk_res(K_DROP, 8'd0, 1'b0, V_OK, 1'b1);
                    cnt = cnt + 2'd1;
                end
                bun.slot[cnt] = mk_res(K_VERDICT, 8'd0, 1'b0,
                                       (n_kept != '0) ? V_OK : V_NO_ENTRIES, 1'b1);
                cnt = cnt + 2'd1;
                n_phase = PH_DONE;
            end
        end
        bun.n = cnt;
    end

    assign o_push       = i_accept && (cnt != 2'd0);
    assign o_bundle     = bun;
    assign o_entry_pre  = r_kept;
    assign o_entry_post = n_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hcount  <= '0;
            r_sig     <= '0;
            r_meth    <= 1'b0;
            r_size    <= '0;
            r_name    <= '0;
            r_extra   <= '0;
            r_data    <= '0;
            r_kept    <= '0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hcount  <= n_hcount;
            r_sig     <= n_sig;
            r_meth    <= n_meth;
            r_size    <= n_size;
            r_name    <= n_name;
            r_extra   <= n_extra;
            r_data    <= n_data;
            r_kept    <= n_kept;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ----- src/zsep_queue.sv -----
// Small register queue that carries result bundles from the walker to the output stage.
module zsep_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- src/zsep_back.sv -----
// Output stage: holds one bundle and hands out its results one word per cycle while i_stall is low.
module zsep_back
    import zsep_pkg::*;
#(
    parameter int ENTRY_INDEX_BITS = ENTRY_INDEX_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  t_bundle                     i_bundle,
    input  logic [ENTRY_INDEX_BITS-1:0] i_entry_pre,
    input  logic [ENTRY_INDEX_BITS-1:0] i_entry_post,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [2:0]                  o_kind,
    output logic [7:0]                  o_value,
    output logic [ENTRY_INDEX_BITS-1:0] o_entry_number,
    output logic                        o_last_of_entry,
    output logic [1:0]                  o_verdict
);

    logic                        r_full;
    logic [1:0]                  r_idx;
    t_bundle                     r_bun;
    logic [ENTRY_INDEX_BITS-1:0] r_pre, r_post;
    t_res                        cur;
    logic                        take, last_word;

    assign cur       = r_bun.slot[r_idx];
    assign take      = r_full && !i_stall;
    assign last_word = take && (r_idx == r_bun.n - 2'd1);
    assign o_pop     = i_q_valid && (!r_full || last_word);

    assign o_valid         = r_full;
    assign o_kind          = cur.kind;
    assign o_value         = cur.value;
    assign o_entry_number  = cur.post ? r_post : r_pre;
    assign o_last_of_entry = cur.last;
    assign o_verdict       = cur.verdict;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun  <= i_bundle;
            r_pre  <= i_entry_pre;
            r_post <= i_entry_post;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last_word) r_full <= 1'b0;
            else           r_idx  <= r_idx + 2'd1;
        end
    end

endmodule

// ----- src/zip_stored_entry_parser_top.sv -----
// Top level of the ZIP stored-entry parser: walker, bundle queue and output stage.
// The parser takes one archive byte word per clock while the queue is not full,
// and keeps that rate while headers, names, extra fields and data stream past.
// Each input word causes zero to three result words (a byte, an entry event, a
// withdrawal and the verdict); they travel as one bundle through a four-deep
// queue and leave the output stage at one word per cycle while i_stall is low.
// Input stall rises only when the queue is full. After the final verdict every
// further input word is taken and ignored until reset.
module zip_stored_entry_parser_top
    import zsep_pkg::*;
#(
    parameter int ENTRY_INDEX_BITS = ENTRY_INDEX_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_byte_in,
    input  logic                        i_has_byte,
    input  logic                        i_end_of_file,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_kind,
    output logic [7:0]                  o_value,
    output logic [ENTRY_INDEX_BITS-1:0] o_entry_number,
    output logic                        o_last_of_entry,
    output logic [1:0]                  o_verdict
);

    localparam int QW = $bits(t_bundle) + 2 * ENTRY_INDEX_BITS;

    logic                        accept, push, pop, q_valid, q_full;
    t_bundle                     f_bundle, b_bundle;
    logic [ENTRY_INDEX_BITS-1:0] f_pre, f_post, b_pre, b_post;
    logic [QW-1:0]               q_out;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    zsep_front #(.ENTRY_INDEX_BITS(ENTRY_INDEX_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_in    (i_byte_in),
        .i_has_byte   (i_has_byte),
        .i_end_of_file(i_end_of_file),
        .o_push       (push),
        .o_bundle     (f_bundle),
        .o_entry_pre  (f_pre),
        .o_entry_post (f_post)
    );

    zsep_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_bundle, f_pre, f_post}),
        .i_pop  (pop),
        .o_data (q_out),
        .o_valid(q_valid),
        .o_full (q_full)
    );

    assign {b_bundle, b_pre, b_post} = q_out;

    zsep_back #(.ENTRY_INDEX_BITS(ENTRY_INDEX_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_bundle       (b_bundle),
        .i_entry_pre    (b_pre),
        .i_entry_post   (b_post),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_entry_number (o_entry_number),
        .o_last_of_entry(o_last_of_entry),
        .o_verdict      (o_verdict)
    );

    // The queue is never written while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("bundle pushed into a full queue");

    // The verdict is the final word the block ever delivers.
    a_verdict_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_kind == K_VERDICT) |=> !o_valid)
        else $error("result delivered after the verdict");

    // Last-of-entry marks only data bytes and empty entries.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_entry) |-> (o_kind == K_DATA || o_kind == K_EMPTY))
        else $error("last-of-entry on a wrong kind");

    // A nonzero verdict code appears only on a verdict word.
    a_verdict_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != V_OK) |-> (o_kind == K_VERDICT))
        else $error("verdict code on a non-verdict word");

endmodule
